// ----- rtl/tsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the touch swipe classifier
// Swipe codes, command codes, register indexes, field widths and the
// reset values of the configuration registers other than the sensor enable.
// ----------------------------------------------------------------------------
package tsc_pkg;

    // Fixed field widths
    localparam int THR_BITS  = 12;
    localparam int TIME_BITS = 32;
    localparam int IDX_BITS  = 3;
    localparam int CFG_BITS  = 32;

    // Swipe result codes
    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_LEFT  = 3'd1,
        GEST_RIGHT = 3'd2,
        GEST_UP    = 3'd3,
        GEST_DOWN  = 3'd4
    } swipe_t;

    // Command codes carried by an input word
    localparam logic CMD_POLL    = 1'b0;
    localparam logic CMD_CONSUME = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_SENSOR_ENABLE = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_MIN_H_TRAVEL  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_MAX_H_SLOP    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_MIN_V_TRAVEL  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MAX_V_SLOP    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_TOP_STRIP     = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_MAX_GESTURE   = 3'd6;

    // Register reset values
    localparam logic [THR_BITS-1:0]  RST_MIN_H_TRAVEL = 12'd70;
    localparam logic [THR_BITS-1:0]  RST_MAX_H_SLOP   = 12'd60;
    localparam logic [THR_BITS-1:0]  RST_MIN_V_TRAVEL = 12'd70;
    localparam logic [THR_BITS-1:0]  RST_MAX_V_SLOP   = 12'd60;
    localparam logic [THR_BITS-1:0]  RST_TOP_STRIP    = 12'd40;
    localparam logic [TIME_BITS-1:0] RST_MAX_GESTURE  = 32'd900;

endpackage
`default_nettype wire

// ----- rtl/touch_swipe_classifier.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// touch_swipe_classifier: swipe classifier for polled touch samples
// Tracks a press from touch samples and classifies the release as a left,
// right, up or down swipe against programmable travel, slop, time and top-strip limits.
// ----------------------------------------------------------------------------
//  channel  | handshake           | contents
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_stall | command, touching, sample_x/y, now_ms
//  out      | out_valid/out_stall | swipe, active, current_x/y, just_pressed,
//           |                     | press_x/y, press_duration
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
//  One word per cycle while in_stall is low: tracking state and the result
//  register update at the accepting edge, so the result appears in the next cycle.
//  The only loop is the tracking state feeding the next word's classification.
//  in_stall is raised only while a result waits and out_stall is high.
//  Reset clears tracking state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module touch_swipe_classifier #(
    parameter int COORD_BITS = 12
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // input channel
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire                           command,
    input  wire                           touching,
    input  wire  [COORD_BITS-1:0]         sample_x,
    input  wire  [COORD_BITS-1:0]         sample_y,
    input  wire  [tsc_pkg::TIME_BITS-1:0] now_ms,
    // output channel
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic [2:0]                    swipe,
    output logic                          active,
    output logic [COORD_BITS-1:0]         current_x,
    output logic [COORD_BITS-1:0]         current_y,
    output logic                          just_pressed,
    output logic [COORD_BITS-1:0]         press_x,
    output logic [COORD_BITS-1:0]         press_y,
    output logic [tsc_pkg::TIME_BITS-1:0] press_duration,
    // configuration channel
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [tsc_pkg::IDX_BITS-1:0]  cfg_index,
    input  wire  [tsc_pkg::CFG_BITS-1:0]  cfg_data
);
    import tsc_pkg::*;

    // Difference width: covers coordinates and thresholds plus sign
    localparam int DW = ((COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS) + 2;

    // Configuration registers
    logic                 sensor_enable_reg;
    logic [THR_BITS-1:0]  min_h_travel_reg;
    logic [THR_BITS-1:0]  max_h_slop_reg;
    logic [THR_BITS-1:0]  min_v_travel_reg;
    logic [THR_BITS-1:0]  max_v_slop_reg;
    logic [THR_BITS-1:0]  top_strip_reg;
    logic [TIME_BITS-1:0] max_gesture_reg;

    // Tracking state
    logic                  tracking_reg, tracking_next;
    logic                  pressed_reg, pressed_next;
    logic                  suppress_reg, suppress_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;

    // Result register
    logic                  out_valid_reg;
    swipe_t                swipe_reg, swipe_next;
    logic                  active_reg;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic                  jp_reg;
    logic [COORD_BITS-1:0] press_x_reg, press_x_next;
    logic [COORD_BITS-1:0] press_y_reg, press_y_next;
    logic [TIME_BITS-1:0]  dur_reg, dur_next;

    // Classification signals
    logic signed [DW-1:0] dx, dy, adx, ady;
    logic signed [DW-1:0] h_trv, h_slop, v_trv, v_slop;
    logic [TIME_BITS-1:0] dt;
    swipe_t               class_swipe;

    logic in_accept;
    logic cfg_accept;

    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_enable_reg <= 1'b0;
            min_h_travel_reg  <= RST_MIN_H_TRAVEL;
            max_h_slop_reg    <= RST_MAX_H_SLOP;
            min_v_travel_reg  <= RST_MIN_V_TRAVEL;
            max_v_slop_reg    <= RST_MAX_V_SLOP;
            top_strip_reg     <= RST_TOP_STRIP;
            max_gesture_reg   <= RST_MAX_GESTURE;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_SENSOR_ENABLE: sensor_enable_reg <= cfg_data[0];
                REG_MIN_H_TRAVEL:  min_h_travel_reg  <= cfg_data[THR_BITS-1:0];
                REG_MAX_H_SLOP:    max_h_slop_reg    <= cfg_data[THR_BITS-1:0];
                REG_MIN_V_TRAVEL:  min_v_travel_reg  <= cfg_data[THR_BITS-1:0];
                REG_MAX_V_SLOP:    max_v_slop_reg    <= cfg_data[THR_BITS-1:0];
                REG_TOP_STRIP:     top_strip_reg     <= cfg_data[THR_BITS-1:0];
                REG_MAX_GESTURE:   max_gesture_reg   <= cfg_data[TIME_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Classify the motion from start point to last tracked point
    always_comb
    begin
        dx     = $signed({{(DW-COORD_BITS){1'b0}}, last_x_reg}) -
                 $signed({{(DW-COORD_BITS){1'b0}}, start_x_reg});
        dy     = $signed({{(DW-COORD_BITS){1'b0}}, last_y_reg}) -
                 $signed({{(DW-COORD_BITS){1'b0}}, start_y_reg});
        adx    = dx[DW-1] ? -dx : dx;
        ady    = dy[DW-1] ? -dy : dy;
        h_trv  = $signed({{(DW-THR_BITS){1'b0}}, min_h_travel_reg});
        h_slop = $signed({{(DW-THR_BITS){1'b0}}, max_h_slop_reg});
        v_trv  = $signed({{(DW-THR_BITS){1'b0}}, min_v_travel_reg});
        v_slop = $signed({{(DW-THR_BITS){1'b0}}, max_v_slop_reg});
        dt     = now_ms - start_time_reg;

        class_swipe = GEST_NONE;
        if (dt > max_gesture_reg)
            class_swipe = GEST_NONE;
        else if (ady <= h_slop && dx <= -h_trv)
            class_swipe = GEST_LEFT;
        else if (ady <= h_slop && dx >= h_trv)
            class_swipe = GEST_RIGHT;
        else if (adx <= v_slop && dy <= -v_trv)
            class_swipe = GEST_UP;
        else if (adx <= v_slop && dy >= v_trv &&
                 {{(DW-COORD_BITS){1'b0}}, start_y_reg} <=
                 {{(DW-THR_BITS){1'b0}}, top_strip_reg})
            class_swipe = GEST_DOWN;
    end

    // Advance tracking state for the incoming word
    always_comb
    begin
        tracking_next   = tracking_reg;
        pressed_next    = pressed_reg;
        suppress_next   = suppress_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        start_time_next = start_time_reg;
        swipe_next      = GEST_NONE;

        if (command == CMD_CONSUME)
        begin
            suppress_next = 1'b1;
        end
        else
        begin
            pressed_next = 1'b0;
            if (sensor_enable_reg)
            begin
                if (touching)
                begin
                    if (!tracking_reg)
                    begin
                        tracking_next   = 1'b1;
                        pressed_next    = 1'b1;
                        start_x_next    = sample_x;
                        start_y_next    = sample_y;
                        start_time_next = now_ms;
                    end
                    last_x_next = sample_x;
                    last_y_next = sample_y;
                end
                else if (tracking_reg)
                begin
                    tracking_next = 1'b0;
                    if (suppress_reg)
                        suppress_next = 1'b0;
                    else
                        swipe_next = class_swipe;
                end
            end
        end
    end

    // Form the result word from the updated state
    always_comb
    begin
        cur_x_next   = tracking_next ? last_x_next : '0;
        cur_y_next   = tracking_next ? last_y_next : '0;
        press_x_next = pressed_next ? start_x_next : '0;
        press_y_next = pressed_next ? start_y_next : '0;
        if (tracking_next && now_ms >= start_time_next)
            dur_next = now_ms - start_time_next;
        else
            dur_next = '0;
    end

    // Hold tracking state, update on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg   <= 1'b0;
            pressed_reg    <= 1'b0;
            suppress_reg   <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            start_time_reg <= '0;
        end
        else if (in_accept)
        begin
            tracking_reg   <= tracking_next;
            pressed_reg    <= pressed_next;
            suppress_reg   <= suppress_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            start_time_reg <= start_time_next;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Load the result word on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            swipe_reg   <= swipe_next;
            active_reg  <= tracking_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            jp_reg      <= pressed_next;
            press_x_reg <= press_x_next;
            press_y_reg <= press_y_next;
            dur_reg     <= dur_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign swipe          = swipe_reg;
    assign active         = active_reg;
    assign current_x      = cur_x_reg;
    assign current_y      = cur_y_reg;
    assign just_pressed   = jp_reg;
    assign press_x        = press_x_reg;
    assign press_y        = press_y_reg;
    assign press_duration = dur_reg;

endmodule
`default_nettype wire

// ----- rtl/tsc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsc_checker: port-level checks for the touch swipe classifier
// Watches the channels and the result words and flags inconsistent results.
// ----------------------------------------------------------------------------
module tsc_checker #(
    parameter int COORD_BITS = 12
) (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           in_valid,
    input wire                           in_stall,
    input wire                           out_valid,
    input wire                           out_stall,
    input wire [2:0]                     swipe,
    input wire                           active,
    input wire [COORD_BITS-1:0]          current_x,
    input wire [COORD_BITS-1:0]          current_y,
    input wire                           just_pressed,
    input wire [COORD_BITS-1:0]          press_x,
    input wire [COORD_BITS-1:0]          press_y,
    input wire [tsc_pkg::TIME_BITS-1:0]  press_duration
);
    import tsc_pkg::*;

    // An accepted word yields a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word produced no result");

    // A stalled result stays valid and holds its swipe, active and duration fields
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(swipe) && $stable(active)
            && $stable(press_duration))
        else $error("stalled result changed");

    // A swipe is only reported on a release
    a_swipe_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && swipe != GEST_NONE |-> !active)
        else $error("swipe reported while finger tracked");

    // An inactive result carries no point and no duration
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> current_x == '0 && current_y == '0
            && press_duration == '0 && !just_pressed)
        else $error("inactive result carries tracking data");

    // A fresh press reports its own point as the tracked point
    a_fresh_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && just_pressed |-> current_x == press_x && current_y == press_y)
        else $error("fresh press inconsistent");

endmodule

bind touch_swipe_classifier tsc_checker #(.COORD_BITS(COORD_BITS)) u_tsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .swipe          (swipe),
    .active         (active),
    .current_x      (current_x),
    .current_y      (current_y),
    .just_pressed   (just_pressed),
    .press_x        (press_x),
    .press_y        (press_y),
    .press_duration (press_duration)
);
`default_nettype wire
